/* design/mwpc_pkg.sv */
// Shared types, constants and width helpers for the max window pixel count unit.
package mwpc_pkg;

    localparam int IMAGE_SIDE_W  = 11;
    localparam int WINDOW_SIDE_W = 7;
    localparam int MAX_COUNT_W   = 13;
    localparam int CFG_INDEX_W   = 2;
    localparam int PIXEL_TDATA_W = 8;
    localparam int COUNT_TDATA_W = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_SIDE  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_SIDE = 2'd1;

    typedef struct packed {
        logic frame_clear;
        logic frame_end;
        logic at_origin;
    } front_status_t;

    typedef struct packed {
        logic busy;
        logic last_done;
    } back_status_t;

    // index width for a store of the given depth, at least one bit
    function automatic int idx_w(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

    // packed width of one queued pixel item
    function automatic int item_w(input int pos_w, input int ha_w);
        return 2 * pos_w + 2 * ha_w + 7;
    endfunction

endpackage

/* design/mwpc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module mwpc_ram
    import mwpc_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [idx_w(DEPTH)-1:0]  waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [idx_w(DEPTH)-1:0]  raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

/* design/mwpc_front.sv */
// Front end: config registers, raster position tracking and per-pixel classification.
module mwpc_front
    import mwpc_pkg::*;
#(
    parameter int MAX_SIDE   = 1024,
    parameter int MAX_WINDOW = 64
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_INDEX_W-1:0]   cfg_index,
    input  logic [IMAGE_SIDE_W-1:0]  cfg_data,
    input  logic                     pix_valid,
    output logic                     pix_ready,
    input  logic                     pix,
    output logic                     item_push,
    output logic [item_w(idx_w(MAX_SIDE), idx_w(MAX_WINDOW * MAX_SIDE))-1:0] item,
    input  logic                     queue_full,
    output front_status_t            status
);

    localparam int POS_W  = idx_w(MAX_SIDE);
    localparam int HA_W   = idx_w(MAX_WINDOW * MAX_SIDE);
    localparam int SIDE_W = $clog2(MAX_SIDE + 1);
    localparam int K_W    = $clog2(MAX_WINDOW + 1);
    localparam int HIST_DEPTH = MAX_WINDOW * MAX_SIDE;

    typedef struct packed {
        logic              px;
        logic [POS_W-1:0]  col;
        logic [POS_W-1:0]  col_back;
        logic [HA_W-1:0]   hist_wr;
        logic [HA_W-1:0]   hist_rd;
        logic              first_row;
        logic              first_col;
        logic              sub_hist;
        logic              sub_copy;
        logic              score;
        logic              last;
    } item_t;

    logic [SIDE_W-1:0] side_reg, side_next;
    logic [K_W-1:0]    k_reg, k_next;
    logic [POS_W-1:0]  row_reg, row_next;
    logic [POS_W-1:0]  col_reg, col_next;
    logic [HA_W-1:0]   wr_base_reg, wr_base_next;
    logic [HA_W-1:0]   rd_base_reg, rd_base_next;

    logic  accept;
    logic  cfg_write;
    logic  row_end;
    logic  frame_end;
    item_t cur;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid & cfg_ready;
    assign pix_ready = ~queue_full;
    assign accept    = pix_valid & pix_ready;
    assign item_push = accept;
    assign item      = cur;

    assign row_end   = (32'(col_reg) + 32'd1 == 32'(side_reg));
    assign frame_end = row_end & (32'(row_reg) + 32'd1 == 32'(side_reg));

    // classification of the current pixel
    always_comb
    begin
        cur.px        = pix;
        cur.col       = col_reg;
        cur.col_back  = POS_W'(32'(col_reg) - 32'(k_reg));
        cur.hist_wr   = HA_W'(32'(wr_base_reg) + 32'(col_reg));
        cur.hist_rd   = HA_W'(32'(rd_base_reg) + 32'(col_reg));
        cur.first_row = (row_reg == '0);
        cur.first_col = (col_reg == '0);
        cur.sub_hist  = (32'(row_reg) >= 32'(k_reg));
        cur.sub_copy  = (32'(col_reg) >= 32'(k_reg));
        cur.score     = (k_reg != '0)
                        && (32'(row_reg) + 32'd1 >= 32'(k_reg))
                        && (32'(col_reg) + 32'd1 >= 32'(k_reg));
        cur.last      = frame_end;
    end

    // config decode, saturating to the supported range
    always_comb
    begin
        side_next = side_reg;
        k_next    = k_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_IMAGE_SIDE:
                begin
                    if (cfg_data == '0)
                        side_next = SIDE_W'(1);
                    else if (32'(cfg_data) > MAX_SIDE)
                        side_next = SIDE_W'(MAX_SIDE);
                    else
                        side_next = SIDE_W'(cfg_data);
                end
                REG_WINDOW_SIDE:
                begin
                    if (32'(cfg_data[WINDOW_SIDE_W-1:0]) > MAX_WINDOW)
                        k_next = K_W'(MAX_WINDOW);
                    else
                        k_next = K_W'(cfg_data[WINDOW_SIDE_W-1:0]);
                end
                default:
                begin
                    side_next = side_reg;
                end
            endcase
        end
    end

    // raster position and history row bases
    always_comb
    begin
        row_next     = row_reg;
        col_next     = col_reg;
        wr_base_next = wr_base_reg;
        rd_base_next = rd_base_reg;
        priority if (cfg_write)
        begin
            row_next     = '0;
            col_next     = '0;
            wr_base_next = '0;
            rd_base_next = '0;
        end
        else if (accept)
        begin
            if (!row_end)
            begin
                col_next = POS_W'(32'(col_reg) + 32'd1);
            end
            else if (frame_end)
            begin
                row_next     = '0;
                col_next     = '0;
                wr_base_next = '0;
                rd_base_next = '0;
            end
            else
            begin
                col_next = '0;
                row_next = POS_W'(32'(row_reg) + 32'd1);
                if (32'(wr_base_reg) + MAX_SIDE >= HIST_DEPTH)
                    wr_base_next = '0;
                else
                    wr_base_next = HA_W'(32'(wr_base_reg) + MAX_SIDE);
                // oldest row of the window starts once row k is reached
                if (32'(row_reg) + 32'd1 == 32'(k_reg))
                    rd_base_next = '0;
                else if (32'(row_reg) + 32'd1 > 32'(k_reg))
                begin
                    if (32'(rd_base_reg) + MAX_SIDE >= HIST_DEPTH)
                        rd_base_next = '0;
                    else
                        rd_base_next = HA_W'(32'(rd_base_reg) + MAX_SIDE);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg    <= SIDE_W'(1);
            k_reg       <= K_W'(1);
            row_reg     <= '0;
            col_reg     <= '0;
            wr_base_reg <= '0;
            rd_base_reg <= '0;
        end
        else
        begin
            side_reg    <= side_next;
            k_reg       <= k_next;
            row_reg     <= row_next;
            col_reg     <= col_next;
            wr_base_reg <= wr_base_next;
            rd_base_reg <= rd_base_next;
        end
    end

    assign status.frame_clear = cfg_write;
    assign status.frame_end   = accept & frame_end & ~cfg_write;
    assign status.at_origin   = (row_reg == '0) && (col_reg == '0);

endmodule

/* design/mwpc_queue.sv */
// Small FIFO between the front end and the back end.
module mwpc_queue
    import mwpc_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [WIDTH-1:0]  push_data,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output logic [WIDTH-1:0]  head_data
);

    localparam int PTR_W = idx_w(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full       = (32'(count_reg) == DEPTH);
    assign head_valid = (count_reg != '0);
    assign head_data  = slot_reg[rd_ptr_reg];
    assign do_push    = push & ~full;
    assign do_pop     = pop & head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (32'(wr_ptr_reg) == DEPTH - 1) ? '0 : PTR_W'(32'(wr_ptr_reg) + 32'd1);
        if (do_pop)
            rd_ptr_next = (32'(rd_ptr_reg) == DEPTH - 1) ? '0 : PTR_W'(32'(rd_ptr_reg) + 32'd1);
        if (do_push && !do_pop)
            count_next = CNT_W'(32'(count_reg) + 32'd1);
        else if (do_pop && !do_push)
            count_next = CNT_W'(32'(count_reg) - 32'd1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* design/mwpc_back.sv */
// Back end: column count and history memories, window sum, best tracking, result register.
module mwpc_back
    import mwpc_pkg::*;
#(
    parameter int MAX_SIDE   = 1024,
    parameter int MAX_WINDOW = 64
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     item_valid,
    input  logic [item_w(idx_w(MAX_SIDE), idx_w(MAX_WINDOW * MAX_SIDE))-1:0] item,
    output logic                     item_pop,
    input  logic                     frame_clear,
    output logic                     res_valid,
    input  logic                     res_ready,
    output logic [MAX_COUNT_W-1:0]   res_count,
    output back_status_t             status
);

    localparam int POS_W      = idx_w(MAX_SIDE);
    localparam int HIST_DEPTH = MAX_WINDOW * MAX_SIDE;
    localparam int HA_W       = idx_w(HIST_DEPTH);
    localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W      = $clog2(MAX_WINDOW * MAX_WINDOW + MAX_WINDOW + 1);

    typedef struct packed {
        logic              px;
        logic [POS_W-1:0]  col;
        logic [POS_W-1:0]  col_back;
        logic [HA_W-1:0]   hist_wr;
        logic [HA_W-1:0]   hist_rd;
        logic              first_row;
        logic              first_col;
        logic              sub_hist;
        logic              sub_copy;
        logic              score;
        logic              last;
    } item_t;

    item_t head;
    item_t s1_reg;
    logic  s1_valid_reg;
    logic  s1_adv;

    // forwarding from the item that wrote in the same cycle as the read
    logic             fwd_col_reg, fwd_copy_reg, fwd_hist_reg;
    logic [CNT_W-1:0] prev_cnt_reg;
    logic             prev_px_reg;

    logic [CNT_W-1:0] col_rd, copy_rd;
    logic             hist_rd;
    logic [CNT_W-1:0] col_prev, copy_val;
    logic             hist_val;
    logic [CNT_W-1:0] cnt_new;
    logic [SUM_W-1:0] ws_reg, ws_new;
    logic [SUM_W-1:0] best_reg, best_cand;
    logic [SUM_W+MAX_COUNT_W-1:0] best_ext;

    logic                   out_valid_reg;
    logic [MAX_COUNT_W-1:0] out_count_reg;

    assign head     = item;
    assign s1_adv   = s1_valid_reg & (~s1_reg.last | ~out_valid_reg | res_ready);
    assign item_pop = item_valid & (~s1_valid_reg | s1_adv);

    mwpc_ram #(.WIDTH(CNT_W), .DEPTH(MAX_SIDE)) u_col_ram (
        .clk   (clk),
        .we    (s1_adv),
        .waddr (s1_reg.col),
        .wdata (cnt_new),
        .re    (item_pop),
        .raddr (head.col),
        .rdata (col_rd)
    );

    // second copy of the column counts, read k columns behind
    mwpc_ram #(.WIDTH(CNT_W), .DEPTH(MAX_SIDE)) u_copy_ram (
        .clk   (clk),
        .we    (s1_adv),
        .waddr (s1_reg.col),
        .wdata (cnt_new),
        .re    (item_pop),
        .raddr (head.col_back),
        .rdata (copy_rd)
    );

    mwpc_ram #(.WIDTH(1), .DEPTH(HIST_DEPTH)) u_hist_ram (
        .clk   (clk),
        .we    (s1_adv),
        .waddr (s1_reg.hist_wr),
        .wdata (s1_reg.px),
        .re    (item_pop),
        .raddr (head.hist_rd),
        .rdata (hist_rd)
    );

    assign col_prev = fwd_col_reg  ? prev_cnt_reg : col_rd;
    assign copy_val = fwd_copy_reg ? prev_cnt_reg : copy_rd;
    assign hist_val = fwd_hist_reg ? prev_px_reg  : hist_rd;

    always_comb
    begin
        logic [CNT_W:0] cnt_wide;
        logic [SUM_W:0] ws_wide;
        cnt_wide = (s1_reg.first_row ? '0 : (CNT_W+1)'(col_prev))
                   + (CNT_W+1)'(s1_reg.px)
                   - ((s1_reg.sub_hist && hist_val) ? (CNT_W+1)'(1) : '0);
        cnt_new  = cnt_wide[CNT_W-1:0];
        ws_wide  = (s1_reg.first_col ? '0 : (SUM_W+1)'(ws_reg))
                   + (SUM_W+1)'(cnt_new)
                   - (s1_reg.sub_copy ? (SUM_W+1)'(copy_val) : '0);
        ws_new   = ws_wide[SUM_W-1:0];
        best_cand = (s1_reg.score && (ws_new > best_reg)) ? ws_new : best_reg;
        best_ext  = (SUM_W+MAX_COUNT_W)'(best_cand);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_col_reg   <= 1'b0;
            fwd_copy_reg  <= 1'b0;
            fwd_hist_reg  <= 1'b0;
            ws_reg        <= '0;
            best_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_pop)
            begin
                s1_valid_reg <= 1'b1;
                fwd_col_reg  <= s1_adv && (head.col == s1_reg.col);
                fwd_copy_reg <= s1_adv && (head.col_back == s1_reg.col);
                fwd_hist_reg <= s1_adv && (head.hist_rd == s1_reg.hist_wr);
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end

            // a new result may replace one taken in the same cycle
            if (s1_adv && s1_reg.last)
                out_valid_reg <= 1'b1;
            else if (res_valid && res_ready)
                out_valid_reg <= 1'b0;

            if (frame_clear)
            begin
                best_reg <= '0;
            end
            else if (s1_adv)
            begin
                ws_reg <= ws_new;
                if (s1_reg.last)
                begin
                    best_reg <= '0;
                end
                else
                begin
                    best_reg <= best_cand;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_pop)
            s1_reg <= head;
        if (s1_adv)
        begin
            prev_cnt_reg <= cnt_new;
            prev_px_reg  <= s1_reg.px;
            if (s1_reg.last)
                out_count_reg <= best_ext[MAX_COUNT_W-1:0];
        end
    end

    assign res_valid        = out_valid_reg;
    assign res_count        = out_count_reg;
    assign status.busy      = s1_valid_reg | out_valid_reg;
    assign status.last_done = s1_adv & s1_reg.last;

endmodule

/* design/max_window_pixel_count_unit.sv */
// Top level: maximum dark-pixel count over all K-by-K windows of a square binary image.
// Throughput: one pixel per clock while the back end is not stalled; it stalls only when the
//   frame's last pixel waits on a result that is still held in the output register.
// Result path: the frame's last pixel passes a queue slot, the memory read and the sum
//   update into the output register before the frame result is valid.
// Reset: rst_n clears positions, sums, queue and handshakes; image and window sides
//   reset to 1. Memories are not cleared: the first row of a frame ignores old counts.
module max_window_pixel_count_unit
    import mwpc_pkg::*;
#(
    parameter int MAX_SIDE   = 1024,
    parameter int MAX_WINDOW = 64
)
(
    input  logic                      clk,
    input  logic                      rst_n,

    // config write channel: index 0 image_side, index 1 window_side
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_W-1:0]    cfg_index,
    input  logic [IMAGE_SIDE_W-1:0]   cfg_data,

    // pixel stream in
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [PIXEL_TDATA_W-1:0]  s_axis_tdata,   // [0] pixel, [7:1] zero

    // result stream out
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [COUNT_TDATA_W-1:0]  m_axis_tdata    // [12:0] max_count, [15:13] zero
);

    localparam int POS_W  = idx_w(MAX_SIDE);
    localparam int HA_W   = idx_w(MAX_WINDOW * MAX_SIDE);
    localparam int ITEM_W = item_w(POS_W, HA_W);
    localparam int QUEUE_DEPTH = 4;

    logic              q_push;
    logic [ITEM_W-1:0] q_push_data;
    logic              q_full;
    logic              q_pop;
    logic              q_head_valid;
    logic [ITEM_W-1:0] q_head_data;
    logic [MAX_COUNT_W-1:0] res_count;

    front_status_t front_st;
    back_status_t  back_st;

    // front: config registers, raster position, per-pixel flags and addresses
    mwpc_front #(
        .MAX_SIDE   (MAX_SIDE),
        .MAX_WINDOW (MAX_WINDOW)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .pix_valid  (s_axis_tvalid),
        .pix_ready  (s_axis_tready),
        .pix        (s_axis_tdata[0]),
        .item_push  (q_push),
        .item       (q_push_data),
        .queue_full (q_full),
        .status     (front_st)
    );

    // decouples the front from stalls at the result side
    mwpc_queue #(
        .WIDTH (ITEM_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_push_data),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_data  (q_head_data)
    );

    // back: column counts, row history, window sum, best count, result register
    mwpc_back #(
        .MAX_SIDE   (MAX_SIDE),
        .MAX_WINDOW (MAX_WINDOW)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (q_head_valid),
        .item        (q_head_data),
        .item_pop    (q_pop),
        .frame_clear (front_st.frame_clear),
        .res_valid   (m_axis_tvalid),
        .res_ready   (m_axis_tready),
        .res_count   (res_count),
        .status      (back_st)
    );

    assign m_axis_tdata = COUNT_TDATA_W'(res_count);

    // a frame's last pixel puts the raster position back at the origin
    assert property (@(posedge clk) disable iff (!rst_n)
        front_st.frame_end |=> front_st.at_origin)
        else $error("position not at origin after frame end");

    // a config write abandons the frame and restarts the raster
    assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_ready) |=> front_st.at_origin)
        else $error("position not cleared by config write");

    // a result appears only when the back end retires a frame's last pixel
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(back_st.last_done))
        else $error("result without frame end");

    // the last pixel only retires when the output register can take the result
    assert property (@(posedge clk) disable iff (!rst_n)
        back_st.last_done |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result overwrote a pending transaction");

endmodule
